FILE: rtl/gda_pkg.sv
// Shared types and constants for the gamepad direction autorepeat block.
package gda_pkg;

  localparam int unsigned CMD_W       = 3;
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 8;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  // Command codes on s_axis_tuser.
  localparam logic [2:0] CMD_TICK  = 3'd0;
  localparam logic [2:0] CMD_DOWN  = 3'd1;
  localparam logic [2:0] CMD_UP    = 3'd2;
  localparam logic [2:0] CMD_AXIS  = 3'd3;
  localparam logic [2:0] CMD_UNPLG = 3'd4;

  // Button codes.
  localparam logic [3:0] BTN_START      = 4'd4;
  localparam logic [3:0] BTN_DPAD_UP    = 4'd5;
  localparam logic [3:0] BTN_DPAD_RIGHT = 4'd8;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;

  // Actions.
  localparam logic [2:0] ACT_DIR_KEY = 3'd5;
  localparam logic [2:0] ACT_FOCUS   = 3'd6;

  // Direction codes with "none" at zero: direction + 1.
  localparam logic [2:0] DCODE_NONE  = 3'd0;
  localparam logic [2:0] DCODE_UP    = 3'd1;
  localparam logic [2:0] DCODE_DOWN  = 3'd2;
  localparam logic [2:0] DCODE_LEFT  = 3'd3;
  localparam logic [2:0] DCODE_RIGHT = 3'd4;

  // Register indexes.
  localparam logic [1:0] REG_DELAY    = 2'd0;
  localparam logic [1:0] REG_INTERVAL = 2'd1;
  localparam logic [1:0] REG_THRESH   = 2'd2;
  localparam logic [1:0] REG_FOCUS    = 2'd3;

  localparam logic [15:0] RST_DELAY    = 16'd260;
  localparam logic [15:0] RST_INTERVAL = 16'd80;
  localparam logic [14:0] RST_THRESH   = 15'd18000;

  typedef enum logic [2:0] {
    K_TICK,
    K_FACE,
    K_DPAD_DN,
    K_DPAD_UP,
    K_AXIS_X,
    K_AXIS_Y,
    K_CLEAR
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [3:0]  arg;
    logic [15:0] value;
  } req_t;

  typedef struct packed {
    logic                  valid;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

endpackage

FILE: rtl/gamepad_direction_autorepeat.sv
// Top level of the gamepad direction autorepeat block.
//
// Input stream (s_axis_*): one gamepad event or millisecond tick per request,
// command on tuser. Output stream (m_axis_*): at most one action per input
// request, action on tuser, direction on tdata. Config channel (cfg_*): one
// register write per request, always ready; write only while the block is idle.
//
// Throughput: one input request per cycle while m_axis is not stalled. An accepted
// request passes the front classifier into the two-entry queue register, then the
// back end pops it and writes its result into the output register.
// The back end, which does all state updates as it pops a request, sets the rate.
//
// When m_axis_tready is low the result is held in the output register; the
// back end stops draining the queue, and s_axis_tready drops once the queue is
// full. Reset empties the queue, clears the tracking state, loads the register
// defaults (delay 260, interval 80, threshold 18000, direction keys).
module gamepad_direction_autorepeat #(
  parameter int unsigned COUNTER_BITS = 16,
  parameter int unsigned AXIS_BITS    = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [3:0] button, [5:4] axis_id, [21:6] axis_value, [23:22] zero
  input  logic [gda_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // [2:0] cmd
  input  logic [gda_pkg::CMD_W-1:0]         s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [1:0] direction, [7:2] zero
  output logic [gda_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // [2:0] action
  output logic [2:0]                        m_axis_tuser,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [gda_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [gda_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import gda_pkg::*;

  req_t    push_req, pop_req;
  logic    q_push, q_full, q_pop, q_empty;
  cfg_wr_t cfg_wr;

  assign cfg_ready_o  = 1'b1;
  assign cfg_wr.valid = cfg_valid_i;
  assign cfg_wr.idx   = cfg_index_i;
  assign cfg_wr.data  = cfg_data_i;

  gda_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_req_o       (push_req)
  );

  gda_fifo #(
    .WIDTH ($bits(req_t)),
    .DEPTH (2)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (push_req),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (pop_req),
    .empty_o (q_empty)
  );

  gda_back #(
    .COUNTER_BITS (COUNTER_BITS),
    .AXIS_BITS    (AXIS_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_i      (cfg_wr),
    .q_empty_i     (q_empty),
    .q_req_i       (pop_req),
    .q_pop_o       (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

FILE: rtl/gda_front.sv
// Front end: takes input events and classifies them into requests.
module gda_front (
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [gda_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  input  logic [gda_pkg::CMD_W-1:0]         s_axis_tuser,
  input  logic                              q_full_i,
  output logic                              q_push_o,
  output gda_pkg::req_t                     q_req_o
);
  import gda_pkg::*;

  logic [3:0]  button;
  logic [1:0]  axis_id;
  logic        keep;

  assign button  = s_axis_tdata[3:0];
  assign axis_id = s_axis_tdata[5:4];

  assign s_axis_tready = !q_full_i;
  assign q_push_o      = s_axis_tvalid && !q_full_i && keep;

  always_comb begin
    keep          = 1'b0;
    q_req_o.kind  = K_TICK;
    q_req_o.arg   = button;
    q_req_o.value = s_axis_tdata[21:6];
    case (s_axis_tuser)
      CMD_TICK: begin
        keep = 1'b1;
      end
      CMD_DOWN: begin
        if (button <= BTN_START) begin
          keep         = 1'b1;
          q_req_o.kind = K_FACE;
        end else if (button <= BTN_DPAD_RIGHT) begin
          keep         = 1'b1;
          q_req_o.kind = K_DPAD_DN;
          q_req_o.arg  = button - BTN_DPAD_UP;
        end
      end
      CMD_UP: begin
        if (button inside {[BTN_DPAD_UP:BTN_DPAD_RIGHT]}) begin
          keep         = 1'b1;
          q_req_o.kind = K_DPAD_UP;
          q_req_o.arg  = button - BTN_DPAD_UP;
        end
      end
      CMD_AXIS: begin
        if (axis_id == AXIS_X) begin
          keep         = 1'b1;
          q_req_o.kind = K_AXIS_X;
        end else if (axis_id == AXIS_Y) begin
          keep         = 1'b1;
          q_req_o.kind = K_AXIS_Y;
        end
      end
      CMD_UNPLG: begin
        keep         = 1'b1;
        q_req_o.kind = K_CLEAR;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

endmodule

FILE: rtl/gda_fifo.sv
// Small register FIFO between the front and back ends.
module gda_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

FILE: rtl/gda_back.sv
// Back end: direction tracking, autorepeat timing and the output register.
module gda_back #(
  parameter int unsigned COUNTER_BITS = 16,
  parameter int unsigned AXIS_BITS    = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  gda_pkg::cfg_wr_t                 cfg_wr_i,
  input  logic                             q_empty_i,
  input  gda_pkg::req_t                    q_req_i,
  output logic                             q_pop_o,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [gda_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  output logic [2:0]                       m_axis_tuser
);
  import gda_pkg::*;

  localparam int unsigned SH    = 16 - AXIS_BITS;
  localparam int unsigned CMP_W = (COUNTER_BITS > 16) ? COUNTER_BITS : 16;

  // Configuration
  logic [15:0] dly_q, ivl_q;
  logic [14:0] thr_q;
  logic        focus_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dly_q   <= RST_DELAY;
      ivl_q   <= RST_INTERVAL;
      thr_q   <= RST_THRESH;
      focus_q <= 1'b0;
    end else if (cfg_wr_i.valid) begin
      case (cfg_wr_i.idx)
        REG_DELAY:    dly_q   <= cfg_wr_i.data;
        REG_INTERVAL: ivl_q   <= cfg_wr_i.data;
        REG_THRESH:   thr_q   <= cfg_wr_i.data[14:0];
        REG_FOCUS:    focus_q <= cfg_wr_i.data[0];
        default:      focus_q <= focus_q;
      endcase
    end
  end

  // State
  logic [1:0]                     held_q [4];
  logic [1:0]                     held_d [4];
  logic [2:0]                     cnt_q, cnt_d;
  logic signed [AXIS_BITS-1:0]    sx_q, sx_d, sy_q, sy_d;
  logic signed [AXIS_BITS-1:0]    sx_n, sy_n;
  logic [2:0]                     sdir_q, sdir_d, act_q, act_d;
  logic [COUNTER_BITS-1:0]        el_q, el_d;
  logic                           rep_q, rep_d;

  logic                           out_valid_q, out_valid_d;
  logic [2:0]                     out_act_q, out_act_d;
  logic [1:0]                     out_dir_q, out_dir_d;

  logic                           pop;
  logic                           emit;
  logic [2:0]                     emit_act;
  logic [1:0]                     emit_dir;
  logic                           recheck, stick_upd;
  logic [2:0]                     k;
  logic [2:0]                     want;
  logic [1:0]                     top_idx;
  logic [2:0]                     scode;
  logic signed [15:0]             narrowed;
  logic signed [AXIS_BITS:0]      xe, ye;
  logic [16:0]                    ax, ay, thr_s;
  logic [15:0]                    lim16;
  logic [CMP_W-1:0]               lim, cmax;

  assign pop      = !q_empty_i && (!out_valid_q || m_axis_tready);
  assign q_pop_o  = pop;
  assign narrowed = $signed(q_req_i.value) >>> SH;
  assign sx_n     = (pop && q_req_i.kind == K_AXIS_X) ? narrowed[AXIS_BITS-1:0] : sx_q;
  assign sy_n     = (pop && q_req_i.kind == K_AXIS_Y) ? narrowed[AXIS_BITS-1:0] : sy_q;
  assign xe       = {sx_n[AXIS_BITS-1], sx_n};
  assign ye       = {sy_n[AXIS_BITS-1], sy_n};
  assign ax       = 17'(xe[AXIS_BITS] ? -xe : xe);
  assign ay       = 17'(ye[AXIS_BITS] ? -ye : ye);
  assign thr_s    = {2'b00, thr_q} >> SH;
  assign cmax     = CMP_W'({COUNTER_BITS{1'b1}});
  assign emit_act = focus_q ? ACT_FOCUS : ACT_DIR_KEY;

  always_comb begin
    held_d    = held_q;
    cnt_d     = cnt_q;
    sx_d      = sx_q;
    sy_d      = sy_q;
    sdir_d    = sdir_q;
    act_d     = act_q;
    el_d      = el_q;
    rep_d     = rep_q;
    emit      = 1'b0;
    out_act_d = out_act_q;
    emit_dir  = 2'd0;
    recheck   = 1'b0;
    stick_upd = 1'b0;
    k         = 3'd0;
    want      = DCODE_NONE;
    top_idx   = 2'd0;
    scode     = DCODE_NONE;
    lim16     = rep_q ? ivl_q : dly_q;
    lim       = '0;
    if (pop) begin
      case (q_req_i.kind)
        K_TICK: begin
          if (act_q != DCODE_NONE) begin
            if (el_q != {COUNTER_BITS{1'b1}}) begin
              el_d = el_q + 1'b1;
            end
            if (lim16 == 16'd0) begin
              lim16 = 16'd1;
            end
            lim = CMP_W'(lim16);
            if (lim > cmax) begin
              lim = cmax;
            end
            if (CMP_W'(el_d) >= lim) begin
              el_d      = '0;
              rep_d     = 1'b1;
              emit      = 1'b1;
              out_act_d = emit_act;
              emit_dir  = 2'(act_q - 3'd1);
            end
          end
        end
        K_FACE: begin
          emit      = 1'b1;
          out_act_d = q_req_i.arg[2:0];
        end
        K_DPAD_DN, K_DPAD_UP: begin
          for (int i = 0; i < 4; i++) begin
            if (3'(i) < cnt_q && held_q[i] != q_req_i.arg[1:0]) begin
              held_d[k[1:0]] = held_q[i];
              k              = k + 3'd1;
            end
          end
          cnt_d = k;
          if (q_req_i.kind == K_DPAD_DN && k < 3'd4) begin
            held_d[k[1:0]] = q_req_i.arg[1:0];
            cnt_d          = k + 3'd1;
          end
          recheck = 1'b1;
        end
        K_AXIS_X: begin
          sx_d      = sx_n;
          stick_upd = 1'b1;
        end
        K_AXIS_Y: begin
          sy_d      = sy_n;
          stick_upd = 1'b1;
        end
        K_CLEAR: begin
          cnt_d  = 3'd0;
          sx_d   = '0;
          sy_d   = '0;
          sdir_d = DCODE_NONE;
          act_d  = DCODE_NONE;
          el_d   = '0;
          rep_d  = 1'b0;
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end

    if (stick_upd) begin
      if (ax > ay && ax > thr_s) begin
        scode = sx_d[AXIS_BITS-1] ? DCODE_LEFT : DCODE_RIGHT;
      end else if (ay > thr_s) begin
        scode = sy_d[AXIS_BITS-1] ? DCODE_UP : DCODE_DOWN;
      end
      if (scode != sdir_q) begin
        sdir_d  = scode;
        recheck = 1'b1;
      end
    end

    if (recheck) begin
      top_idx = 2'(cnt_d - 3'd1);
      want    = (cnt_d != 3'd0) ? {1'b0, held_d[top_idx]} + 3'd1 : sdir_d;
      if (want != act_q) begin
        act_d = want;
        el_d  = '0;
        rep_d = 1'b0;
        if (want != DCODE_NONE) begin
          emit      = 1'b1;
          out_act_d = emit_act;
          emit_dir  = 2'(want - 3'd1);
        end
      end
    end

    out_valid_d = out_valid_q && !m_axis_tready;
    out_dir_d   = out_dir_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_dir_d   = emit_dir;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= 3'd0;
      sx_q        <= '0;
      sy_q        <= '0;
      sdir_q      <= DCODE_NONE;
      act_q       <= DCODE_NONE;
      el_q        <= '0;
      rep_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      sx_q        <= sx_d;
      sy_q        <= sy_d;
      sdir_q      <= sdir_d;
      act_q       <= act_d;
      el_q        <= el_d;
      rep_q       <= rep_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_q    <= held_d;
    out_act_q <= out_act_d;
    out_dir_q <= out_dir_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_act_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W - 2){1'b0}}, out_dir_q};

endmodule

FILE: rtl/gda_checker.sv
// Port-level checks for the gamepad direction autorepeat block, bound to the top.
module gda_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [gda_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input logic [2:0]                       m_axis_tuser,
  input logic                             cfg_ready_o
);
  import gda_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("result valid during reset");

  a_action_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser <= ACT_FOCUS)
    else $error("action code out of range");

  a_face_dir_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != ACT_DIR_KEY && m_axis_tuser != ACT_FOCUS
      |-> m_axis_tdata == '0)
    else $error("direction set on a button action");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("config channel not ready");

endmodule

bind gamepad_direction_autorepeat gda_checker u_gda_checker (.*);

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the gamepad direction autorepeat block.
module tb_top;
  import gda_pkg::*;

  localparam logic [3:0] BTN_SOUTH      = 4'd0;
  localparam logic [3:0] BTN_DPAD_DOWN  = 4'd6;
  localparam logic [3:0] BTN_DPAD_LEFT  = 4'd7;
  localparam logic [3:0] BTN_UNUSED_LO  = 4'd9;
  localparam logic [3:0] BTN_UNUSED_HI  = 4'd15;
  localparam logic [2:0] CMD_RSVD5      = 3'd5;
  localparam logic [2:0] CMD_RSVD7      = 3'd7;
  localparam logic [1:0] AXIS_RSVD2     = 2'd2;
  localparam logic [1:0] AXIS_RSVD3     = 2'd3;
  localparam int         COUNT_MAX      = 65535;
  localparam int         SETTLE_CYCLES  = 8;
  localparam int         CYCLE_LIMIT    = 400000;
  localparam int         PHASE_HALF     = 70;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [3:0]         button;
    logic [1:0]         axis_id;
    logic signed [15:0] axis_value;
  } pad_ev_t;

  typedef struct packed {
    logic [2:0] action;
    logic [1:0] direction;
  } pad_act_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic [CMD_W-1:0] s_axis_tuser = '0;
  logic m_axis_tready = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  wire logic s_axis_tready;
  wire logic m_axis_tvalid;
  wire logic [OUT_TDATA_W-1:0] m_axis_tdata;
  wire logic [2:0] m_axis_tuser;
  wire logic cfg_ready_o;

  gamepad_direction_autorepeat dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Predicted block state
  logic [1:0]  dpad_stack [4];
  int          stack_depth;
  int          pos_x, pos_y;
  logic [2:0]  stick_code, live_code;
  int          hold_ticks;
  bit          repeating;
  int          delay_cfg, interval_cfg, thresh_cfg;
  bit          focus_cfg;

  pad_ev_t     ev_q [$];
  pad_act_t    action_q [$];
  pad_ev_t     cur_ev;
  bit          step_fires;
  pad_act_t    step_act;
  int          src_idle_pct, sink_idle_pct;
  int          mismatches = 0;
  int          cycle_cnt = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic void clear_pad();
    stack_depth = 0;
    pos_x = 0;
    pos_y = 0;
    stick_code = DCODE_NONE;
    live_code = DCODE_NONE;
    hold_ticks = 0;
    repeating = 1'b0;
  endfunction

  function automatic pad_act_t dir_act(logic [2:0] code);
    logic [2:0] d;
    d = code - 3'd1;
    return '{action: focus_cfg ? ACT_FOCUS : ACT_DIR_KEY, direction: d[1:0]};
  endfunction

  function automatic void reselect(output bit fires, output pad_act_t act);
    logic [2:0] want;
    fires = 1'b0;
    act = '0;
    want = stack_depth != 0 ? {1'b0, dpad_stack[stack_depth-1]} + 3'd1 : stick_code;
    if (want != live_code) begin
      live_code = want;
      hold_ticks = 0;
      repeating = 1'b0;
      if (want != DCODE_NONE) begin
        fires = 1'b1;
        act = dir_act(want);
      end
    end
  endfunction

  function automatic void press_dpad(logic [1:0] dir, bit down, output bit fires,
                                     output pad_act_t act);
    int k;
    k = 0;
    for (int i = 0; i < stack_depth; i++) begin
      if (dpad_stack[i] != dir) begin
        dpad_stack[k] = dpad_stack[i];
        k++;
      end
    end
    stack_depth = k;
    if (down && stack_depth < 4) begin
      dpad_stack[stack_depth] = dir;
      stack_depth++;
    end
    reselect(fires, act);
  endfunction

  function automatic void step_pad(input pad_ev_t ev, output bit fires, output pad_act_t act);
    logic [3:0] rel;
    int lim, ax, ay;
    logic [2:0] code;
    fires = 1'b0;
    act = '0;
    rel = ev.button - BTN_DPAD_UP;
    case (ev.cmd)
      CMD_TICK: begin
        if (live_code != DCODE_NONE) begin
          if (hold_ticks < COUNT_MAX) hold_ticks++;
          lim = repeating ? interval_cfg : delay_cfg;
          if (lim == 0) lim = 1;
          if (hold_ticks >= lim) begin
            hold_ticks = 0;
            repeating = 1'b1;
            fires = 1'b1;
            act = dir_act(live_code);
          end
        end
      end
      CMD_DOWN: begin
        if (ev.button <= BTN_START) begin
          fires = 1'b1;
          act = '{action: ev.button[2:0], direction: 2'd0};
        end else if (ev.button <= BTN_DPAD_RIGHT) begin
          press_dpad(rel[1:0], 1'b1, fires, act);
        end
      end
      CMD_UP: begin
        if (ev.button >= BTN_DPAD_UP && ev.button <= BTN_DPAD_RIGHT)
          press_dpad(rel[1:0], 1'b0, fires, act);
      end
      CMD_AXIS: begin
        if (ev.axis_id == AXIS_X || ev.axis_id == AXIS_Y) begin
          if (ev.axis_id == AXIS_X) pos_x = int'(ev.axis_value);
          else pos_y = int'(ev.axis_value);
          ax = pos_x < 0 ? -pos_x : pos_x;
          ay = pos_y < 0 ? -pos_y : pos_y;
          if (ax > ay && ax > thresh_cfg) code = pos_x < 0 ? DCODE_LEFT : DCODE_RIGHT;
          else if (ay > thresh_cfg) code = pos_y < 0 ? DCODE_UP : DCODE_DOWN;
          else code = DCODE_NONE;
          if (code != stick_code) begin
            stick_code = code;
            reselect(fires, act);
          end
        end
      end
      CMD_UNPLG: clear_pad();
      default: ;
    endcase
  endfunction

  function automatic pad_ev_t mk_ev(logic [2:0] cmd, logic [3:0] button, logic [1:0] axis_id,
                                    logic [15:0] value);
    return '{cmd: cmd, button: button, axis_id: axis_id, axis_value: value};
  endfunction

  function automatic pad_ev_t rand_pad_event();
    pad_ev_t ev;
    int pick, mag;
    ev.cmd = 3'($urandom);
    ev.button = 4'($urandom);
    ev.axis_id = 2'($urandom);
    ev.axis_value = 16'($urandom);
    pick = $urandom_range(99);
    if (pick < 40) begin
      ev.cmd = CMD_TICK;
    end else if (pick < 55) begin
      ev.cmd = CMD_DOWN;
      ev.button = 4'(BTN_DPAD_UP + $urandom_range(3));
    end else if (pick < 68) begin
      ev.cmd = CMD_UP;
      ev.button = 4'(BTN_DPAD_UP + $urandom_range(3));
    end else if (pick < 83) begin
      ev.cmd = CMD_AXIS;
      ev.axis_id = 2'($urandom_range(1));
      case ($urandom_range(3))
        0: ;
        1: begin
          // just around the threshold
          mag = thresh_cfg + int'($urandom_range(2)) - 1;
          ev.axis_value = 16'($urandom_range(1) ? -mag : mag);
        end
        2: ev.axis_value = $urandom_range(1) ? 16'h8000 : 16'h7FFF;
        default: ev.axis_value = '0;
      endcase
    end else if (pick < 90) begin
      ev.cmd = CMD_DOWN;
      ev.button = 4'($urandom_range(BTN_START));
    end else if (pick < 94) begin
      ev.cmd = 3'($urandom_range(CMD_UP, CMD_DOWN));
    end else if (pick < 96) begin
      ev.cmd = CMD_AXIS;
      ev.axis_id = 2'(AXIS_RSVD2 + $urandom_range(1));
    end else if (pick < 98) begin
      ev.cmd = 3'(CMD_RSVD5 + $urandom_range(2));
    end else begin
      ev.cmd = CMD_UNPLG;
    end
    return ev;
  endfunction

  // Wait until all requests are accepted and all actions have come back.
  task automatic settle();
    while (ev_q.size() != 0 || s_axis_tvalid || action_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_DELAY:    delay_cfg = int'(val);
      REG_INTERVAL: interval_cfg = int'(val);
      REG_THRESH:   thresh_cfg = int'(val[14:0]);
      REG_FOCUS:    focus_cfg = val[0];
      default: ;
    endcase
  endtask

  task automatic load_regs(logic [15:0] delay, logic [15:0] interval, logic [14:0] thresh,
                           bit focus);
    @(posedge clk_i);
    write_reg(REG_DELAY, delay);
    write_reg(REG_INTERVAL, interval);
    write_reg(REG_THRESH, {1'b0, thresh});
    write_reg(REG_FOCUS, {15'd0, focus});
    cfg_valid_i <= 1'b0;
  endtask

  // Request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        step_pad(cur_ev, step_fires, step_act);
        if (step_fires) action_q.push_back(step_act);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (ev_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          cur_ev = ev_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {2'b00, cur_ev.axis_value, cur_ev.axis_id, cur_ev.button};
          s_axis_tuser <= cur_ev.cmd;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Action monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (action_q.size() == 0) begin
          $error("unexpected action %0d direction %0d", m_axis_tuser, m_axis_tdata[1:0]);
          mismatches++;
        end else begin
          if (m_axis_tuser != action_q[0].action) begin
            $error("action: expected %0d, got %0d", action_q[0].action, m_axis_tuser);
            mismatches++;
          end
          if (m_axis_tdata[1:0] != action_q[0].direction) begin
            $error("direction: expected %0d, got %0d", action_q[0].direction,
                   m_axis_tdata[1:0]);
            mismatches++;
          end
          void'(action_q.pop_front());
        end
      end
      m_axis_tready <= $urandom_range(99) >= sink_idle_pct;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("[gamepad_direction_autorepeat] ERROR");
      $finish;
    end
  end

  initial begin
    clear_pad();
    delay_cfg = int'(RST_DELAY);
    interval_cfg = int'(RST_INTERVAL);
    thresh_cfg = int'(RST_THRESH);
    focus_cfg = 1'b0;
    src_idle_pct = 6;
    sink_idle_pct = 82;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed, reset register values
    for (int b = int'(BTN_SOUTH); b <= int'(BTN_START); b++)
      ev_q.push_back(mk_ev(CMD_DOWN, 4'(b), AXIS_X, 16'd0));
    ev_q.push_back(mk_ev(CMD_UP, BTN_SOUTH, AXIS_X, 16'd0));
    ev_q.push_back(mk_ev(CMD_DOWN, BTN_UNUSED_LO, AXIS_X, 16'd0));
    ev_q.push_back(mk_ev(CMD_DOWN, BTN_UNUSED_HI, AXIS_Y, 16'hFFFF));
    ev_q.push_back(mk_ev(CMD_RSVD5, BTN_DPAD_UP, AXIS_X, 16'd0));
    ev_q.push_back(mk_ev(CMD_RSVD7, BTN_DPAD_UP, AXIS_X, 16'd0));
    ev_q.push_back(mk_ev(CMD_AXIS, BTN_SOUTH, AXIS_RSVD2, 16'h8000));
    ev_q.push_back(mk_ev(CMD_AXIS, BTN_SOUTH, AXIS_RSVD3, 16'h7FFF));
    ev_q.push_back(mk_ev(CMD_AXIS, BTN_SOUTH, AXIS_X, 16'h8000));
    ev_q.push_back(mk_ev(CMD_DOWN, BTN_DPAD_UP, AXIS_X, 16'd0));
    ev_q.push_back(mk_ev(CMD_DOWN, BTN_DPAD_RIGHT, AXIS_X, 16'd0));
    ev_q.push_back(mk_ev(CMD_DOWN, BTN_DPAD_UP, AXIS_X, 16'd0));
    ev_q.push_back(mk_ev(CMD_UP, BTN_DPAD_LEFT, AXIS_X, 16'd0));
    ev_q.push_back(mk_ev(CMD_UP, BTN_DPAD_UP, AXIS_X, 16'd0));
    ev_q.push_back(mk_ev(CMD_UP, BTN_DPAD_RIGHT, AXIS_X, 16'd0));
    ev_q.push_back(mk_ev(CMD_AXIS, BTN_SOUTH, AXIS_Y, 16'h7FFF));
    ev_q.push_back(mk_ev(CMD_UNPLG, BTN_DPAD_DOWN, AXIS_X, 16'd0));
    ev_q.push_back(mk_ev(CMD_TICK, BTN_SOUTH, AXIS_X, 16'd0));
    settle();

    // zero delay and interval, zero threshold, focus moves
    load_regs(16'd0, 16'd0, 15'd0, 1'b1);
    @(negedge clk_i);
    ev_q.push_back(mk_ev(CMD_AXIS, BTN_SOUTH, AXIS_X, 16'd1));
    ev_q.push_back(mk_ev(CMD_TICK, BTN_SOUTH, AXIS_X, 16'd0));
    ev_q.push_back(mk_ev(CMD_TICK, BTN_SOUTH, AXIS_X, 16'd0));
    settle();

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: ;
        1: load_regs(16'd3, 16'd2, RST_THRESH, 1'b0);
        2: begin
          load_regs(16'hFFFF, 16'hFFFF, 15'h7FFF, 1'b1);
          src_idle_pct = 82;
          sink_idle_pct = 6;
        end
        3: load_regs(16'd1, 16'd1, 15'd1000, 1'b0);
        default: begin
          load_regs(16'($urandom_range(12, 1)), 16'($urandom_range(6, 1)), 15'($urandom),
                    1'($urandom));
          src_idle_pct = 0;
          sink_idle_pct = 0;
        end
      endcase
      for (int h = 0; h < 2; h++) begin
        @(negedge clk_i);
        for (int n = 0; n < PHASE_HALF; n++) ev_q.push_back(rand_pad_event());
        settle();
      end
    end

    if (mismatches == 0) begin
      $display("[gamepad_direction_autorepeat] OK");
    end else begin
      $display("[gamepad_direction_autorepeat] ERROR");
    end
    $finish;
  end

endmodule
